@@ hdl/mwms_pkg.sv @@
// Shared types, codes and wall-word helpers for the maze wall map store.
`timescale 1ns / 1ps
`default_nettype none

package mwms_pkg;

    // Default grid shape
    localparam int GRID_COLUMNS_DEF = 16;
    localparam int GRID_ROWS_DEF    = 16;

    // Field widths
    localparam int CELL_W = 10;
    localparam int WALL_W = 2;
    localparam int WORD_W = 8;

    // Wall state codes
    localparam logic [WALL_W-1:0] WS_UNKNOWN = 2'd0;
    localparam logic [WALL_W-1:0] WS_ABSENT  = 2'd1;
    localparam logic [WALL_W-1:0] WS_PRESENT = 2'd2;
    localparam logic [WALL_W-1:0] WS_ERROR   = 2'd3;

    // Side codes
    localparam logic [1:0] SIDE_LEFT   = 2'd0;
    localparam logic [1:0] SIDE_RIGHT  = 2'd1;
    localparam logic [1:0] SIDE_TOP    = 2'd2;
    localparam logic [1:0] SIDE_BOTTOM = 2'd3;

    // Status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    // Command codes
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Number of seed writes run after the border sweep
    localparam logic [2:0] SEED_COUNT = 3'd6;

    typedef enum logic [2:0] {
        FSM_SWEEP,
        FSM_SEED,
        FSM_IDLE,
        FSM_CHECK,
        FSM_NBWR
    } fsm_t;

    // Pull one side out of a cell word
    function automatic logic [WALL_W-1:0] field_get(input logic [WORD_W-1:0] word,
                                                     input logic [1:0] side);
        logic [WALL_W-1:0] f;
        unique case (side)
            SIDE_LEFT:   f = word[1:0];
            SIDE_RIGHT:  f = word[3:2];
            SIDE_TOP:    f = word[5:4];
            SIDE_BOTTOM: f = word[7:6];
            default:     f = word[1:0];
        endcase
        return f;
    endfunction

    // Replace one side of a cell word
    function automatic logic [WORD_W-1:0] field_put(input logic [WORD_W-1:0] word,
                                                     input logic [1:0] side,
                                                     input logic [WALL_W-1:0] v);
        logic [WORD_W-1:0] w;
        w = word;
        unique case (side)
            SIDE_LEFT:   w[1:0] = v;
            SIDE_RIGHT:  w[3:2] = v;
            SIDE_TOP:    w[5:4] = v;
            SIDE_BOTTOM: w[7:6] = v;
            default:     w[1:0] = v;
        endcase
        return w;
    endfunction

    // Side seen from the neighbour across the given side
    function automatic logic [1:0] side_opposite(input logic [1:0] side);
        return {side[1], ~side[0]};
    endfunction

    // Cell word holding only the outer border walls
    function automatic logic [WORD_W-1:0] border_word(input logic first_col,
                                                       input logic last_col,
                                                       input logic top_row,
                                                       input logic bottom_row);
        logic [WORD_W-1:0] w;
        w = '0;
        if (first_col)  w[1:0] = WS_PRESENT;
        if (last_col)   w[3:2] = WS_PRESENT;
        if (top_row)    w[5:4] = WS_PRESENT;
        if (bottom_row) w[7:6] = WS_PRESENT;
        return w;
    endfunction

endpackage

`default_nettype wire

@@ hdl/maze_wall_map_store_top.sv @@
// Maze wall map store: cell memory with one write and one read port, read-check-write sequencer.
//
// Usage:
//   Slave channel s_* carries one command per beat: s_tuser is the command
//   (0 read, 1 write), s_tdata holds cell_index, side and wall_value.
//   Master channel m_* returns one result beat per command: wall_state and
//   status in m_tdata.
//   A read or a rejected write loads its result from the check state; an
//   accepted write loads it from the neighbour-write state, since the cell
//   and its neighbour are written one after the other through the single
//   write port of the cell memory. s_tready is high again in the cycle the
//   result is loaded, so a new command waits until the last one has retired.
//   Reset: the map comes up through an init pass over all
//   GRID_COLUMNS*GRID_ROWS cells (one cell per cycle, border walls) followed
//   by six internal writes (start cell and centre opening). s_tready stays
//   low for the whole pass.
//   Stall: the result sits in an output register; a new command is accepted
//   while it waits, and that command holds before its own result until
//   m_tready frees the register.
`timescale 1ns / 1ps
`default_nettype none

module maze_wall_map_store_top
    import mwms_pkg::*;
#(
    parameter int GRID_COLUMNS = GRID_COLUMNS_DEF,
    parameter int GRID_ROWS    = GRID_ROWS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [9:0] cell_index, [11:10] side, [12] wall_value
    input  wire logic        s_tuser,   // [0] cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // [1:0] wall_state, [3:2] status
);

    localparam int CELLS   = GRID_COLUMNS * GRID_ROWS;
    localparam int AW      = $clog2(CELLS);
    localparam int CW      = $clog2(GRID_COLUMNS);
    localparam int RW      = $clog2(GRID_ROWS);
    localparam int LO_CELL = (GRID_ROWS / 2 - 1) * GRID_COLUMNS + GRID_COLUMNS / 2 - 1;
    localparam int HI_CELL = (GRID_ROWS / 2) * GRID_COLUMNS + GRID_COLUMNS / 2;

    // Cell memory
    logic [WORD_W-1:0] mem [CELLS];
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [WORD_W-1:0] rd_data_reg;

    // Control state
    fsm_t              state_reg, state_next;
    logic [AW-1:0]     addr_cnt_reg, addr_cnt_next;
    logic [CW-1:0]     col_cnt_reg, col_cnt_next;
    logic [RW-1:0]     row_cnt_reg, row_cnt_next;
    logic [2:0]        seed_cnt_reg, seed_cnt_next;
    logic              int_reg, int_next;
    logic              m_tvalid_reg, m_tvalid_next;

    // Command registers
    logic              cmd_reg;
    logic [AW-1:0]     cell_reg;
    logic [1:0]        side_reg;
    logic [WALL_W-1:0] val_reg;
    logic              oor_reg;
    logic [WALL_W-1:0] wall_reg;
    logic [1:0]        status_reg;

    // Datapath controls
    logic              load_user;
    logic              load_seed;
    logic              out_load;
    logic [WALL_W-1:0] out_wall;
    logic [1:0]        out_status;

    // Input decode
    logic [CELL_W-1:0] in_cell;
    logic              in_oor;
    logic              s_beat;

    // Seed command
    logic [AW-1:0]     seed_cell;
    logic [1:0]        seed_side;
    logic [WALL_W-1:0] seed_val;

    // Check helpers
    logic [WALL_W-1:0] old_field;
    logic              wr_ok;
    logic              out_free;
    logic              can_finish;
    logic [AW-1:0]     nb_addr;
    fsm_t              done_next;

    assign in_cell  = s_tdata[CELL_W-1:0];
    assign in_oor   = ({1'b0, in_cell} >= (CELL_W + 1)'(CELLS));
    assign s_tready = (state_reg == FSM_IDLE);
    assign s_beat   = s_tvalid && s_tready;

    // Seed writes that open the start cell and the centre
    always_comb
    begin
        unique case (seed_cnt_reg)
            3'd0:
            begin
                seed_cell = '0;
                seed_side = SIDE_RIGHT;
                seed_val  = WS_ABSENT;
            end
            3'd1:
            begin
                seed_cell = '0;
                seed_side = SIDE_TOP;
                seed_val  = WS_PRESENT;
            end
            3'd2:
            begin
                seed_cell = AW'(LO_CELL);
                seed_side = SIDE_RIGHT;
                seed_val  = WS_ABSENT;
            end
            3'd3:
            begin
                seed_cell = AW'(LO_CELL);
                seed_side = SIDE_TOP;
                seed_val  = WS_ABSENT;
            end
            3'd4:
            begin
                seed_cell = AW'(HI_CELL);
                seed_side = SIDE_LEFT;
                seed_val  = WS_ABSENT;
            end
            3'd5:
            begin
                seed_cell = AW'(HI_CELL);
                seed_side = SIDE_BOTTOM;
                seed_val  = WS_ABSENT;
            end
            default:
            begin
                seed_cell = '0;
                seed_side = SIDE_LEFT;
                seed_val  = WS_UNKNOWN;
            end
        endcase
    end

    // Check the stored side; border sides are never unknown, so an accepted
    // write always has a neighbour
    assign old_field  = field_get(rd_data_reg, side_reg);
    assign wr_ok      = (cmd_reg == CMD_WRITE) && !oor_reg && (old_field == WS_UNKNOWN);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign can_finish = int_reg || out_free;

    always_comb
    begin
        unique case (side_reg)
            SIDE_LEFT:   nb_addr = cell_reg - AW'(1);
            SIDE_RIGHT:  nb_addr = cell_reg + AW'(1);
            SIDE_TOP:    nb_addr = cell_reg + AW'(GRID_COLUMNS);
            SIDE_BOTTOM: nb_addr = cell_reg - AW'(GRID_COLUMNS);
            default:     nb_addr = cell_reg;
        endcase
    end

    // Where to go once a command retires
    always_comb
    begin
        if (!int_reg)
        begin
            done_next = FSM_IDLE;
        end
        else if (seed_cnt_reg == SEED_COUNT)
        begin
            done_next = FSM_IDLE;
        end
        else
        begin
            done_next = FSM_SEED;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_SWEEP:
            begin
                if (addr_cnt_reg == AW'(CELLS - 1))
                begin
                    state_next = FSM_SEED;
                end
            end
            FSM_SEED:
            begin
                state_next = FSM_CHECK;
            end
            FSM_IDLE:
            begin
                if (s_beat)
                begin
                    state_next = FSM_CHECK;
                end
            end
            FSM_CHECK:
            begin
                if (wr_ok)
                begin
                    state_next = FSM_NBWR;
                end
                else if (can_finish)
                begin
                    state_next = done_next;
                end
            end
            FSM_NBWR:
            begin
                if (can_finish)
                begin
                    state_next = done_next;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: memory port, counters and result load
    always_comb
    begin
        mem_we        = 1'b0;
        mem_waddr     = cell_reg;
        mem_wdata     = field_put(rd_data_reg, side_reg, val_reg);
        mem_re        = 1'b0;
        mem_raddr     = cell_reg;
        load_user     = 1'b0;
        load_seed     = 1'b0;
        out_load      = 1'b0;
        out_wall      = old_field;
        out_status    = ST_DONE;
        addr_cnt_next = addr_cnt_reg;
        col_cnt_next  = col_cnt_reg;
        row_cnt_next  = row_cnt_reg;
        seed_cnt_next = seed_cnt_reg;
        int_next      = int_reg;
        unique case (state_reg)
            FSM_SWEEP:
            begin
                mem_we        = 1'b1;
                mem_waddr     = addr_cnt_reg;
                mem_wdata     = border_word(col_cnt_reg == '0,
                                            col_cnt_reg == CW'(GRID_COLUMNS - 1),
                                            row_cnt_reg == RW'(GRID_ROWS - 1),
                                            row_cnt_reg == '0);
                addr_cnt_next = addr_cnt_reg + AW'(1);
                if (col_cnt_reg == CW'(GRID_COLUMNS - 1))
                begin
                    col_cnt_next = '0;
                    row_cnt_next = row_cnt_reg + RW'(1);
                end
                else
                begin
                    col_cnt_next = col_cnt_reg + CW'(1);
                end
            end
            FSM_SEED:
            begin
                load_seed     = 1'b1;
                mem_re        = 1'b1;
                mem_raddr     = seed_cell;
                seed_cnt_next = seed_cnt_reg + 3'd1;
                int_next      = 1'b1;
            end
            FSM_IDLE:
            begin
                if (s_beat)
                begin
                    load_user = 1'b1;
                    mem_re    = !in_oor;
                    mem_raddr = in_cell[AW-1:0];
                    int_next  = 1'b0;
                end
            end
            FSM_CHECK:
            begin
                if (wr_ok)
                begin
                    // Write the cell, fetch the neighbour
                    mem_we    = 1'b1;
                    mem_re    = 1'b1;
                    mem_raddr = nb_addr;
                end
                else if (can_finish)
                begin
                    out_load = !int_reg;
                    if (oor_reg)
                    begin
                        out_wall   = WS_ERROR;
                        out_status = ST_RANGE;
                    end
                    else if (cmd_reg == CMD_WRITE)
                    begin
                        out_status = ST_IGNORED;
                    end
                end
            end
            FSM_NBWR:
            begin
                if (can_finish)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = nb_addr;
                    mem_wdata  = field_put(rd_data_reg, side_opposite(side_reg), val_reg);
                    out_load   = !int_reg;
                    out_wall   = val_reg;
                    out_status = ST_DONE;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Output valid: set on load, drop when taken
    always_comb
    begin
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= FSM_SWEEP;
            addr_cnt_reg <= '0;
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            seed_cnt_reg <= '0;
            int_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            addr_cnt_reg <= addr_cnt_next;
            col_cnt_reg  <= col_cnt_next;
            row_cnt_reg  <= row_cnt_next;
            seed_cnt_reg <= seed_cnt_next;
            int_reg      <= int_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Command and result registers
    always_ff @(posedge clk)
    begin
        if (load_user)
        begin
            cmd_reg  <= s_tuser;
            cell_reg <= in_cell[AW-1:0];
            side_reg <= s_tdata[11:10];
            val_reg  <= s_tdata[12] ? WS_PRESENT : WS_ABSENT;
            oor_reg  <= in_oor;
        end
        else if (load_seed)
        begin
            cmd_reg  <= CMD_WRITE;
            cell_reg <= seed_cell;
            side_reg <= seed_side;
            val_reg  <= seed_val;
            oor_reg  <= 1'b0;
        end
        if (out_load)
        begin
            wall_reg   <= out_wall;
            status_reg <= out_status;
        end
    end

    // Cell memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, status_reg, wall_reg};

    // Read and write never hit the same cell in one cycle
    a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("cell memory read and write collide");

    // Neighbour write only follows an in-range write command
    a_nbwr_is_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_NBWR) |-> (cmd_reg == CMD_WRITE && !oor_reg))
        else $error("neighbour write without a write command");

    // A result beat comes only from a user command retiring
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |->
            $past(state_reg == FSM_CHECK || state_reg == FSM_NBWR) && !$past(int_reg))
        else $error("result beat without a retiring user command");

    // Seed writes never produce a result beat
    a_seed_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (int_reg && (state_reg == FSM_CHECK || state_reg == FSM_NBWR)) |-> !out_load)
        else $error("internal seed write loaded a result");

endmodule

`default_nettype wire
